@@ src/tfis_pkg.sv @@
// tfis_pkg: shared constants and types for the tape feeder index sequencer
// used by the channel interfaces and the top level; no dependencies
`timescale 1ns / 1ps

package tfis_pkg;

    localparam int THRESH_W = 10;
    localparam int ADDR_W   = 8;
    localparam int CMD_W    = 8;
    localparam int DUTY_W   = 8;
    localparam int GAP_W    = 8;
    localparam int TIMER_W  = 9;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [DUTY_W-1:0]   duty_t;
    typedef logic [TIMER_W-1:0]  timer_t;
    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam logic [CMD_W-1:0] CMD_FWD = 8'h46;
    localparam logic [CMD_W-1:0] CMD_REV = 8'h42;

    localparam duty_t DUTY_FIRST_FWD = 8'd150;
    localparam duty_t DUTY_DRIVE     = 8'd200;
    localparam duty_t DUTY_PEEL      = 8'd100;

    // pulse on times, already less the first tick
    localparam timer_t ON_FWD_REST = 9'd14;
    localparam timer_t ON_REV_REST = 9'd19;

    localparam phase_t PH_IDLE  = 3'd0;
    localparam phase_t PH_SLACK = 3'd1;
    localparam phase_t PH_ONE   = 3'd2;
    localparam phase_t PH_TWO   = 3'd3;
    localparam phase_t PH_THREE = 3'd4;
    localparam phase_t PH_PEEL  = 3'd5;

    localparam cfg_idx_t CFG_FEEDER_ADDR = 3'd0;
    localparam cfg_idx_t CFG_MID_THRESH  = 3'd1;
    localparam cfg_idx_t CFG_FWD_HIGH    = 3'd2;
    localparam cfg_idx_t CFG_REV_FIRST   = 3'd3;
    localparam cfg_idx_t CFG_REV_THIRD   = 3'd4;
    localparam cfg_idx_t CFG_TENSION     = 3'd5;
    localparam cfg_idx_t CFG_PULSE_GAP   = 3'd6;
    localparam cfg_idx_t CFG_SLACK       = 3'd7;

endpackage

@@ src/tfis_channels.sv @@
// tfis_channels: valid/ready channel interfaces for request items and results
// depends on tfis_pkg
`timescale 1ns / 1ps

interface tfis_req_if #(parameter int SAMPLE_BITS = 10);
    import tfis_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] opto_sample;
    logic [SAMPLE_BITS-1:0] tension_sample;
    logic                   tension_open;
    logic [ADDR_W-1:0]      frame_addr;
    logic [CMD_W-1:0]       frame_cmd;

    modport source (output valid, req_type, opto_sample, tension_sample, tension_open,
                    frame_addr, frame_cmd, input ready);
    modport sink   (input valid, req_type, opto_sample, tension_sample, tension_open,
                    frame_addr, frame_cmd, output ready);
endinterface

interface tfis_res_if;
    import tfis_pkg::*;

    logic             valid;
    logic             ready;
    duty_t            drive_fwd_duty;
    duty_t            drive_rev_duty;
    duty_t            peel_wind_duty;
    duty_t            peel_unwind_duty;
    logic             busy_res;
    logic             echo_valid;
    logic [CMD_W-1:0] echo_byte;

    modport source (output valid, drive_fwd_duty, drive_rev_duty, peel_wind_duty,
                    peel_unwind_duty, busy_res, echo_valid, echo_byte, input ready);
    modport sink   (input valid, drive_fwd_duty, drive_rev_duty, peel_wind_duty,
                    peel_unwind_duty, busy_res, echo_valid, echo_byte, output ready);
endinterface

@@ src/tape_feeder_index_sequencer_core.sv @@
// tape_feeder_index_sequencer_core: index step sequencer for a tape feeder
// depends on tfis_pkg and the channel interfaces in tfis_channels.sv
`timescale 1ns / 1ps

// usage
//   item channel: one transaction is either a 1 ms tick (req_type 0) carrying
//   the sprocket and tension samples, or a bus frame (req_type 1) with address
//   and command. every transaction yields exactly one result transaction.
//   result channel: motor duties, busy flag and the echo of a matching frame.
//   config port: cfg_we, cfg_index, cfg_data; write only while idle.
// timing
//   one transaction per cycle sustained while result.ready is high; the result
//   is valid in the cycle after the item is taken. the whole step update is
//   one pass of compares and a 9-bit timer decrement, state to result register.
// reset
//   rst_n clears the step state to idle, empties the result register and
//   loads the configuration defaults.
// stall
//   the result register holds while the receiver is not ready; a new item is
//   taken in the same cycle the held result leaves, so ready only drops while
//   a result waits and result.ready is low.

module tape_feeder_index_sequencer_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tfis_req_if.sink               item,
    tfis_res_if.source             result,
    input  logic                   cfg_we,
    input  tfis_pkg::cfg_idx_t     cfg_index,
    input  tfis_pkg::cfg_data_t    cfg_data
);
    import tfis_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    // configuration
    logic [ADDR_W-1:0]   feeder_addr_reg;
    logic [THRESH_W-1:0] mid_thresh_reg;
    logic [THRESH_W-1:0] fwd_high_reg;
    logic [THRESH_W-1:0] rev_first_reg;
    logic [THRESH_W-1:0] rev_third_reg;
    logic [THRESH_W-1:0] tension_thresh_reg;
    logic [GAP_W-1:0]    pulse_gap_reg;
    timer_t              slack_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feeder_addr_reg    <= '0;
            mid_thresh_reg     <= 10'd200;
            fwd_high_reg       <= 10'd500;
            rev_first_reg      <= 10'd300;
            rev_third_reg      <= 10'd250;
            tension_thresh_reg <= 10'd500;
            pulse_gap_reg      <= 8'd50;
            slack_reg          <= 9'd400;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FEEDER_ADDR: feeder_addr_reg    <= cfg_data[ADDR_W-1:0];
                CFG_MID_THRESH:  mid_thresh_reg     <= cfg_data[THRESH_W-1:0];
                CFG_FWD_HIGH:    fwd_high_reg       <= cfg_data[THRESH_W-1:0];
                CFG_REV_FIRST:   rev_first_reg      <= cfg_data[THRESH_W-1:0];
                CFG_REV_THIRD:   rev_third_reg      <= cfg_data[THRESH_W-1:0];
                CFG_TENSION:     tension_thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_PULSE_GAP:   pulse_gap_reg      <= cfg_data[GAP_W-1:0];
                CFG_SLACK:       slack_reg          <= cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // step state
    phase_t phase_reg, phase_next;
    logic   fwd_reg, fwd_next;
    logic   pulse_on_reg, pulse_on_next;
    timer_t timer_reg, timer_next;

    // result register
    logic             res_valid_reg;
    duty_t            fwd_duty_reg, fwd_duty_next;
    duty_t            rev_duty_reg, rev_duty_next;
    duty_t            wind_reg, wind_next;
    duty_t            unwind_reg, unwind_next;
    logic             busy_reg, busy_next;
    logic             echo_v_reg, echo_v_next;
    logic [CMD_W-1:0] echo_b_reg, echo_b_next;

    logic accept;
    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    logic [CMP_W-1:0] opto_c, tens_c;
    logic [CMP_W-1:0] mid_c, fwd_high_c, rev_first_c, rev_third_c, tension_c;
    assign opto_c      = CMP_W'(item.opto_sample);
    assign tens_c      = CMP_W'(item.tension_sample);
    assign mid_c       = CMP_W'(mid_thresh_reg);
    assign fwd_high_c  = CMP_W'(fwd_high_reg);
    assign rev_first_c = CMP_W'(rev_first_reg);
    assign rev_third_c = CMP_W'(rev_third_reg);
    assign tension_c   = CMP_W'(tension_thresh_reg);

    phase_t cur_phase;
    logic   cond;
    duty_t  pulse_duty;
    timer_t timer_dec;
    duty_t  drive;

    always_comb
    begin
        // unused codes fall back to idle
        cur_phase = (phase_reg > PH_PEEL) ? PH_IDLE : phase_reg;

        case (cur_phase)
            PH_ONE:  cond = fwd_reg ? (opto_c < mid_c) : (opto_c < rev_first_c);
            PH_TWO:  cond = opto_c > mid_c;
            default: cond = fwd_reg ? (opto_c < fwd_high_c) : (opto_c < rev_third_c);
        endcase

        pulse_duty = (fwd_reg && cur_phase == PH_ONE) ? DUTY_FIRST_FWD : DUTY_DRIVE;
        timer_dec  = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;

        phase_next    = cur_phase;
        fwd_next      = fwd_reg;
        pulse_on_next = pulse_on_reg;
        timer_next    = timer_reg;
        drive         = '0;
        wind_next     = '0;
        unwind_next   = '0;
        echo_v_next   = 1'b0;
        echo_b_next   = '0;

        if (item.req_type)
        begin
            if (cur_phase == PH_IDLE && item.frame_addr == feeder_addr_reg)
            begin
                echo_v_next   = 1'b1;
                echo_b_next   = item.frame_cmd;
                pulse_on_next = 1'b0;
                timer_next    = '0;
                if (item.frame_cmd == CMD_FWD)
                begin
                    fwd_next   = 1'b1;
                    phase_next = PH_ONE;
                end
                else if (item.frame_cmd == CMD_REV)
                begin
                    fwd_next = 1'b0;
                    if (slack_reg != '0)
                    begin
                        phase_next = PH_SLACK;
                        timer_next = slack_reg;
                    end
                    else
                    begin
                        phase_next = PH_ONE;
                    end
                end
            end
        end
        else
        begin
            case (cur_phase)
                PH_SLACK:
                begin
                    if (timer_reg != '0)
                        unwind_next = DUTY_PEEL;
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                        phase_next = PH_ONE;
                end
                PH_ONE, PH_TWO, PH_THREE:
                begin
                    if (pulse_on_reg)
                    begin
                        drive      = pulse_duty;
                        timer_next = timer_dec;
                        if (timer_dec == '0)
                        begin
                            pulse_on_next = 1'b0;
                            timer_next    = TIMER_W'(pulse_gap_reg);
                        end
                    end
                    else if (timer_reg != '0)
                    begin
                        timer_next = timer_dec;
                    end
                    else if (cond)
                    begin
                        drive         = pulse_duty;
                        pulse_on_next = 1'b1;
                        timer_next    = fwd_reg ? ON_FWD_REST : ON_REV_REST;
                    end
                    else
                    begin
                        phase_next = cur_phase + 1'b1;
                    end
                end
                PH_PEEL:
                begin
                    if (fwd_reg ? (tens_c > tension_c) : item.tension_open)
                        wind_next = DUTY_PEEL;
                    else
                        phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end

        fwd_duty_next = fwd_next ? drive : '0;
        rev_duty_next = fwd_next ? '0 : drive;
        busy_next     = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            fwd_reg       <= 1'b0;
            pulse_on_reg  <= 1'b0;
            timer_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                fwd_reg      <= fwd_next;
                pulse_on_reg <= pulse_on_next;
                timer_reg    <= timer_next;
            end
            if (item.ready)
                res_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_duty_reg <= fwd_duty_next;
            rev_duty_reg <= rev_duty_next;
            wind_reg     <= wind_next;
            unwind_reg   <= unwind_next;
            busy_reg     <= busy_next;
            echo_v_reg   <= echo_v_next;
            echo_b_reg   <= echo_b_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.drive_fwd_duty   = fwd_duty_reg;
    assign result.drive_rev_duty   = rev_duty_reg;
    assign result.peel_wind_duty   = wind_reg;
    assign result.peel_unwind_duty = unwind_reg;
    assign result.busy_res         = busy_reg;
    assign result.echo_valid       = echo_v_reg;
    assign result.echo_byte        = echo_b_reg;

    // state codes past peel never appear
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_PEEL)
        else $error("phase register holds an unused code");

    // a drive pulse only runs inside the three threshold phases
    a_pulse_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_on_reg |-> (phase_reg == PH_ONE || phase_reg == PH_TWO ||
                          phase_reg == PH_THREE))
        else $error("pulse active outside a drive phase");

    // a result never drives both tape directions and never echoes while driving
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (fwd_duty_reg != '0 || rev_duty_reg != '0) |->
            (fwd_duty_reg == '0 || rev_duty_reg == '0) && !echo_v_reg)
        else $error("result drives both directions or mixes echo and drive");

    // an accepted echo leaves a busy state only for a direction command
    a_echo_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && echo_v_next |=> (phase_reg != PH_IDLE) ==
            ($past(item.frame_cmd) == CMD_FWD || $past(item.frame_cmd) == CMD_REV))
        else $error("echoed frame did not start the expected step");

endmodule
